// File: rtl/gfpg_pkg.sv
package gfpg_pkg;

    localparam int TIME_W       = 32;
    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int FRAC_W       = PHASE_BITS - SINE_IDX_W;
    localparam int DIV_STAGES   = TIME_W + PHASE_BITS;
    localparam int POS_W        = 16;
    localparam int AMP_W        = 16;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATH_HEIGHT  = 2'd0,
        REG_PATH_WIDTH   = 2'd1,
        REG_CYCLE_PERIOD = 2'd2
    } t_cfg_reg;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 32'd1000;

    typedef logic [AMP_W-1:0] t_sine_tab [0:SINE_ENTRIES];

    // Quarter-wave sine in Q1.15 from an eleven-term Taylor series in Q2.30.
    function automatic logic [AMP_W-1:0] sine_entry(int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        sum = (pos > neg) ? pos - neg : 64'd0;
        sum = (sum + 64'd16384) >> 15;
        if (sum > 64'd32768) begin
            sum = 64'd32768;
        end
        return sum[AMP_W-1:0];
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

// File: rtl/gait_foot_path_generator.sv
// Channel  | Dir | Signals                                  | Beat content
// s (time) | in  | i_s_tvalid, o_s_tready, i_s_tdata[31:0]  | time_now
// m (path) | out | o_m_tvalid, i_m_tready, o_m_tdata[31:0]  | x_pos, y_pos
// cfg      | in  | i_cfg_valid, o_cfg_ready, i_cfg_addr,    | register index, write data
//          |     | i_cfg_data[31:0]                         |
//
// One beat enters per cycle unless the output is held; each beat passes 48 divider steps and then
// six arithmetic stages. The one-bit-per-stage divider forms time mod period and the phase
// fraction.
// Reset (synchronous, active low) clears all valid bits and loads the registers with
// height 0, width 0 and period 1000.
// When the output beat is held by the sink, the whole pipeline freezes; nothing is lost.
module gait_foot_path_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,   // [31:0] time_now
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // [15:0] x_pos, [31:16] y_pos
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gfpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                    i_cfg_data
);
    import gfpg_pkg::*;

    localparam int PW = PHASE_BITS;
    localparam int M_W = PW - 1;           // linear-segment operand, up to a quarter turn
    localparam int MAG_W = PW + 1;         // |4p - 2Q|, up to Q
    localparam int IDX_W = SINE_IDX_W + 1; // table index, up to SINE_ENTRIES

    // Configuration registers. A write lands at once; the sender issues writes only while the pipeline
    // is empty (the block does not enforce this), since several stages read the live register values.
    logic [15:0]       r_height;
    logic [15:0]       r_width;
    logic [TIME_W-1:0] r_period;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
            r_width  <= '0;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_PATH_HEIGHT:  r_height <= i_cfg_data[15:0];
                REG_PATH_WIDTH:   r_width  <= i_cfg_data[15:0];
                REG_CYCLE_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipe moves when the output register is empty or being drained.
    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // Restoring divider, one quotient bit per stage. The first TIME_W stages shift the time in
    // and leave time mod period; the next PHASE_BITS stages shift zeros in and collect the
    // phase fraction in the low bits of r_tq.
    logic              r_dv  [DIV_STAGES];
    logic [TIME_W-1:0] r_rem [DIV_STAGES];
    logic [TIME_W-1:0] r_tq  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic              w_v_in;
        logic [TIME_W-1:0] w_rem_in;
        logic [TIME_W-1:0] w_tq_in;
        logic [TIME_W:0]   w_sh;
        logic              w_ge;
        if (k == 0) begin : g_first
            assign w_v_in   = i_s_tvalid;
            assign w_rem_in = '0;
            assign w_tq_in  = i_s_tdata;
        end else begin : g_next
            assign w_v_in   = r_dv[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_tq_in  = r_tq[k-1];
        end
        if (k < TIME_W) begin : g_mod
            assign w_sh = {w_rem_in, w_tq_in[TIME_W-1]};
        end else begin : g_frac
            assign w_sh = {w_rem_in, 1'b0};
        end
        assign w_ge = w_sh >= {1'b0, r_period};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k] <= w_v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[k] <= w_ge ? TIME_W'(w_sh - {1'b0, r_period}) : w_sh[TIME_W-1:0];
                r_tq[k]  <= {w_tq_in[TIME_W-2:0], (k >= TIME_W) && w_ge};
            end
        end
    end

    // A zero period would make the divider return all ones; the phase is defined as zero.
    logic [PW-1:0] w_phase;
    assign w_phase = (r_period == '0) ? '0 : r_tq[DIV_STAGES-1][PW-1:0];

    // Stage A: classify the phase and form the operands of each segment.
    logic             r_va, r_arc_a, r_neg_a;
    logic [M_W-1:0]   r_m_a;
    logic [MAG_W-1:0] r_mag_a;

    logic [PW+1:0]  w_s4;
    logic [PW+1:0]  w_two_q;
    logic           w_first, w_last;
    assign w_s4    = {w_phase, 2'b00};
    assign w_two_q = (PW + 2)'(1) << (PW + 1);
    assign w_first = w_phase < PW'(1 << (PW - 2));
    assign w_last  = w_phase >= PW'(3 << (PW - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_adv) begin
            r_va <= r_dv[DIV_STAGES-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arc_a <= !w_first && !w_last;
            if (w_first) begin
                r_neg_a <= 1'b0;
                r_m_a   <= M_W'(w_phase);
            end else if (w_last) begin
                r_neg_a <= 1'b1;
                r_m_a   <= M_W'((PW + 1)'(1) << PW) - M_W'(w_phase);
            end else begin
                r_neg_a <= w_s4 >= w_two_q;
                r_m_a   <= '0;
            end
            r_mag_a <= (w_s4 >= w_two_q) ? MAG_W'(w_s4 - w_two_q) : MAG_W'(w_two_q - w_s4);
        end
    end

    // Stage B: table read for the arc, product for the straight segments.
    logic              r_vb, r_arc_b, r_neg_b;
    logic [AMP_W-1:0]  r_a_b, r_d_b;
    logic [FRAC_W-1:0] r_frac_b;
    logic [M_W+15:0]   r_lin_b;

    logic [IDX_W-1:0] w_idx;
    logic [AMP_W-1:0] w_tab_a, w_tab_b;
    assign w_idx   = r_mag_a[MAG_W-1:FRAC_W];
    assign w_tab_a = SINE_TAB[w_idx];
    assign w_tab_b = SINE_TAB[IDX_W'(w_idx[SINE_IDX_W-1:0]) + IDX_W'(1)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_adv) begin
            r_vb <= r_va;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arc_b  <= r_arc_a;
            r_neg_b  <= r_neg_a;
            r_a_b    <= w_tab_a;
            // Past the last entry, or on a falling step, the slope is flat.
            r_d_b    <= (w_idx[SINE_IDX_W] || (w_tab_b < w_tab_a)) ? '0 : w_tab_b - w_tab_a;
            r_frac_b <= r_mag_a[FRAC_W-1:0];
            r_lin_b  <= (M_W + 16)'(r_m_a) * (M_W + 16)'(r_width);
        end
    end

    // Stage C: interpolate the sine; finish the straight-segment magnitude.
    logic             r_vc, r_arc_c, r_neg_c;
    logic [AMP_W-1:0] r_u_c;
    logic [16:0]      r_xm_c;

    logic [AMP_W+FRAC_W-1:0] w_step;
    assign w_step = (AMP_W + FRAC_W)'(r_d_b) * (AMP_W + FRAC_W)'(r_frac_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_adv) begin
            r_vc <= r_vb;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arc_c <= r_arc_b;
            r_neg_c <= r_neg_b;
            r_u_c   <= r_a_b + AMP_W'(w_step >> FRAC_W);
            r_xm_c  <= 17'(r_lin_b >> (PW - 1));
        end
    end

    // Stage D: u*w for the stride, u*u for the lift.
    logic        r_vd, r_arc_d, r_neg_d;
    logic [31:0] r_uw_d, r_uu_d;
    logic [16:0] r_xm_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (w_adv) begin
            r_vd <= r_vc;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arc_d <= r_arc_c;
            r_neg_d <= r_neg_c;
            r_uw_d  <= 32'(r_u_c) * 32'(r_width);
            r_uu_d  <= 32'(r_u_c) * 32'(r_u_c);
            r_xm_d  <= r_xm_c;
        end
    end

    // Stage E: lift times height; pick the horizontal magnitude.
    logic        r_ve, r_arc_e, r_neg_e;
    logic [46:0] r_lh_e;
    logic [16:0] r_xm_e;

    logic [30:0] w_lift;
    assign w_lift = 31'(ONE_Q30 - r_uu_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_adv) begin
            r_ve <= r_vd;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arc_e <= r_arc_d;
            r_neg_e <= r_neg_d;
            r_lh_e  <= 47'(w_lift) * 47'(r_height);
            r_xm_e  <= r_arc_d ? 17'(r_uw_d >> 16) : r_xm_d;
        end
    end

    // Stage F: sign, saturation, output register.
    logic        r_vf;
    logic [31:0] r_out;

    logic [16:0]      w_y_full;
    logic [POS_W-1:0] w_y, w_x;
    assign w_y_full = r_arc_e ? 17'(r_lh_e >> 30) : '0;
    assign w_y      = w_y_full[16] ? 16'hFFFF : w_y_full[15:0];
    always_comb begin
        if (r_neg_e) begin
            w_x = (r_xm_e > 17'd32768) ? 16'h8000 : 16'(17'd0 - r_xm_e);
        end else begin
            w_x = (r_xm_e > 17'd32767) ? 16'h7FFF : r_xm_e[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (w_adv) begin
            r_vf <= r_ve;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {w_y, w_x};
        end
    end

    assign o_m_tvalid = r_vf;
    assign o_m_tdata  = r_out;

endmodule

// File: rtl/gfpg_chk.sv
module gfpg_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [31:0]                     i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [31:0]                     o_m_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [gfpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [31:0]                     i_cfg_data
);
    import gfpg_pkg::*;

    // The input side stalls exactly when an output beat is held back.
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output stall");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("held output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // Every segment keeps the stride magnitude at or below 32767, so the most negative
    // offset code never appears.
    a_x_not_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:0] != 16'h8000)
        else $error("stride offset reached the most negative code");

endmodule

bind gait_foot_path_generator gfpg_chk u_gfpg_chk (.*);
